[rtl/core/lec_pkg.sv]
// ----------------------------------------------------------------------------
// lec_pkg
// shared types and constants of the eigenvector-basis discriminant classifier
// ----------------------------------------------------------------------------
package lec_pkg;

  // input transaction kinds, carried in tuser
  typedef enum logic [2:0] {
    OP_MEAN   = 3'd0,
    OP_VECTOR = 3'd1,
    OP_EIGVAL = 3'd2,
    OP_PRIOR  = 3'd3,
    OP_SAMPLE = 3'd4
  } lec_op_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_FRACTION   = 2'd0,
    REG_DIMS       = 2'd1,
    REG_COMPONENTS = 2'd2,
    REG_CLASSES    = 2'd3
  } lec_reg_e;

  // controller states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SUM_RD,
    ST_SUM_ACC,
    ST_LIMIT,
    ST_CLS_INIT,
    ST_EIG_RD,
    ST_EIG_LD,
    ST_KEEP_CHK,
    ST_MAC_RD,
    ST_MAC_MUL,
    ST_MAC_ACC,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_SQ,
    ST_DIST,
    ST_COMP_NEXT,
    ST_SCORE,
    ST_BEST,
    ST_FINISH
  } lec_state_e;

  localparam logic [63:0] DIST_CAP = 64'h7FFF_FFFF_FFFF_FFFF;

  // controller to datapath
  typedef struct packed {
    logic ready;
    logic c_clr;
    logic c_inc;
    logic d_clr;
    logic d_inc;
    logic k_clr;
    logic k_inc;
    logic sum_clr;
    logic sum_acc;
    logic limit_ld;
    logic eig_ld;
    logic p_clr;
    logic prod_ld;
    logic p_acc;
    logic div_start;
    logic sq_ld;
    logic dist_clr;
    logic dist_acc;
    logic score_ld;
    logic best_upd;
    logic out_ld;
  } lec_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic start;
    logic c_last;
    logic d_last;
    logic k_last;
    logic keep;
    logic div_busy;
    logic out_free;
  } lec_sts_t;

endpackage

[rtl/core/lec_ram.sv]
// ----------------------------------------------------------------------------
// lec_ram
// simple dual-port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module lec_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/core/lec_div.sv]
// ----------------------------------------------------------------------------
// lec_div
// restoring divider, one quotient bit per cycle, magnitude result
// ----------------------------------------------------------------------------
module lec_div #(
  parameter int unsigned NW = 40
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [NW-1:0] num_i,
  input  logic [15:0]          den_i,
  output logic                 busy_o,
  output logic [NW-1:0]        quo_o
);

  localparam int unsigned CNTW = $clog2(NW + 1);

  logic            busy_q, busy_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [15:0]     rem_q, rem_d;
  logic [15:0]     den_q, den_d;
  logic [NW-1:0]   quo_q, quo_d;
  logic [NW-1:0]   mag;
  logic [16:0]     trial;
  logic            qbit;

  // one shift-subtract step per cycle
  always_comb begin
    mag    = num_i[NW-1] ? NW'(-num_i) : NW'(num_i);
    trial  = {rem_q, quo_q[NW-1]};
    qbit   = (trial >= {1'b0, den_q});
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNTW'(NW);
      rem_d  = '0;
      den_d  = den_i;
      quo_d  = mag;
    end else if (busy_q) begin
      rem_d = qbit ? 16'(trial - {1'b0, den_q}) : trial[15:0];
      quo_d = {quo_q[NW-2:0], qbit};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNTW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

[rtl/core/lec_datapath.sv]
// ----------------------------------------------------------------------------
// lec_datapath
// stores, counters, multiply-accumulate, divider and score logic
// ----------------------------------------------------------------------------
module lec_datapath #(
  parameter int unsigned MAX_DIMS    = 64,
  parameter int unsigned MAX_CLASSES = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lec_pkg::lec_cmd_t cmd_i,
  output lec_pkg::lec_sts_t sts_o,
  input  logic              in_accept_i,
  input  logic [2:0]        in_op_i,
  input  logic [5:0]        in_row_i,
  input  logic [5:0]        in_col_i,
  input  logic [31:0]       in_value_i,
  input  logic              in_last_i,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [15:0]       cfg_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        out_class_o,
  output logic [63:0]       out_score_o
);

  localparam int unsigned DW  = $clog2(MAX_DIMS);
  localparam int unsigned KW  = $clog2(MAX_CLASSES);
  localparam int unsigned CW  = $clog2(MAX_DIMS + 1);
  localparam int unsigned KCW = $clog2(MAX_CLASSES + 1);
  localparam int unsigned SW  = 16 + DW;
  localparam int unsigned LW  = 32 + DW;
  localparam int unsigned PW  = 33 + DW;
  localparam int unsigned MW  = PW + 1;
  localparam int unsigned MEAN_DEPTH = MAX_DIMS * (2 ** KW);
  localparam int unsigned VEC_DEPTH  = MAX_DIMS * (2 ** DW);

  // configuration registers
  logic [15:0] frac_q;
  logic [6:0]  dims_q, comps_q;
  logic [2:0]  classes_q;
  logic [31:0] prior_q [MAX_CLASSES];

  // counters and working registers
  logic [DW-1:0]        c_q, d_q;
  logic [KW-1:0]        k_q;
  logic [SW-1:0]        sum_q;
  logic [LW-1:0]        limit_q;
  logic [15:0]          eig_q;
  logic [31:0]          esq_q;
  logic signed [32:0]   prod_q;
  logic signed [PW-1:0] p_q;
  logic [63:0]          sq_q, dist_q;
  logic signed [63:0]   score_q, best_q;
  logic [KW-1:0]        best_k_q;
  logic                 out_valid_q;
  logic [1:0]           out_class_q;
  logic [63:0]          out_score_q;

  // ram ports
  logic [15:0] mean_rd, vec_rd, eig_rd, smp_rd;
  logic        mean_we, vec_we, eig_we, smp_we;
  logic        row_ok, colk_ok, cold_ok;

  // clamped counts
  logic [CW-1:0]  nd, nc;
  logic [KCW-1:0] nk;
  logic [31:0]    dims_x, comps_x, classes_x;

  // arithmetic nets
  logic signed [16:0]   diff;
  logic [MW-1:0]        quo;
  logic                 div_busy;
  logic [64:0]          dist_sum;
  logic [63:0]          sq_raw;
  logic signed [63:0]   prior_x;

  // count clamping
  always_comb begin
    dims_x    = 32'(dims_q);
    comps_x   = 32'(comps_q);
    classes_x = 32'(classes_q);
    nd = CW'((dims_x == 0) ? 1 : ((dims_x > MAX_DIMS) ? MAX_DIMS : dims_x));
    nc = CW'((comps_x == 0) ? 1 : ((comps_x > MAX_DIMS) ? MAX_DIMS : comps_x));
    nk = KCW'((classes_x == 0) ? 1 :
              ((classes_x > MAX_CLASSES) ? MAX_CLASSES : classes_x));
  end

  // load decode
  always_comb begin
    row_ok  = (32'(in_row_i) < MAX_DIMS);
    colk_ok = (32'(in_col_i) < MAX_CLASSES);
    cold_ok = (32'(in_col_i) < MAX_DIMS);
    mean_we = 1'b0;
    vec_we  = 1'b0;
    eig_we  = 1'b0;
    smp_we  = 1'b0;
    if (in_accept_i) begin
      unique case (in_op_i)
        lec_pkg::OP_MEAN:   mean_we = row_ok && colk_ok;
        lec_pkg::OP_VECTOR: vec_we  = row_ok && cold_ok;
        lec_pkg::OP_EIGVAL: eig_we  = cold_ok;
        lec_pkg::OP_SAMPLE: smp_we  = row_ok;
        default: ;
      endcase
    end
  end

  // class means
  lec_ram #(.WIDTH(16), .DEPTH(MEAN_DEPTH)) u_mean_ram (
    .clk_i  (clk_i),
    .we_i   (mean_we),
    .waddr_i({DW'(in_row_i), KW'(in_col_i)}),
    .wdata_i(in_value_i[15:0]),
    .raddr_i({d_q, k_q}),
    .rdata_o(mean_rd)
  );

  // eigenvector matrix
  lec_ram #(.WIDTH(16), .DEPTH(VEC_DEPTH)) u_vec_ram (
    .clk_i  (clk_i),
    .we_i   (vec_we),
    .waddr_i({DW'(in_row_i), DW'(in_col_i)}),
    .wdata_i(in_value_i[15:0]),
    .raddr_i({d_q, c_q}),
    .rdata_o(vec_rd)
  );

  // eigenvalues
  lec_ram #(.WIDTH(16), .DEPTH(MAX_DIMS)) u_eig_ram (
    .clk_i  (clk_i),
    .we_i   (eig_we),
    .waddr_i(DW'(in_col_i)),
    .wdata_i(in_value_i[15:0]),
    .raddr_i(c_q),
    .rdata_o(eig_rd)
  );

  // sample buffer
  lec_ram #(.WIDTH(16), .DEPTH(MAX_DIMS)) u_smp_ram (
    .clk_i  (clk_i),
    .we_i   (smp_we),
    .waddr_i(DW'(in_row_i)),
    .wdata_i(in_value_i[15:0]),
    .raddr_i(d_q),
    .rdata_o(smp_rd)
  );

  // scaled component magnitude
  lec_div #(.NW(MW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  ({p_q, 1'b0}),
    .den_i  (eig_q),
    .busy_o (div_busy),
    .quo_o  (quo)
  );

  // configuration and prior registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_q    <= '0;
      dims_q    <= 7'd64;
      comps_q   <= 7'd64;
      classes_q <= 3'd2;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lec_pkg::REG_FRACTION:   frac_q    <= cfg_data_i;
        lec_pkg::REG_DIMS:       dims_q    <= cfg_data_i[6:0];
        lec_pkg::REG_COMPONENTS: comps_q   <= cfg_data_i[6:0];
        lec_pkg::REG_CLASSES:    classes_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept_i && in_op_i == lec_pkg::OP_PRIOR && colk_ok) begin
      prior_q[KW'(in_col_i)] <= in_value_i;
    end
  end

  // arithmetic helpers
  always_comb begin
    diff     = 17'(signed'(mean_rd)) - 17'(signed'(smp_rd));
    sq_raw   = 64'(quo[31:0]) * 64'(quo[31:0]);
    dist_sum = 65'(dist_q) + 65'(sq_q);
    prior_x  = 64'(signed'(prior_q[k_q]));
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.c_clr) c_q <= '0;
    else if (cmd_i.c_inc) c_q <= c_q + 1'b1;
    if (cmd_i.d_clr) d_q <= '0;
    else if (cmd_i.d_inc) d_q <= d_q + 1'b1;
    if (cmd_i.k_clr) k_q <= '0;
    else if (cmd_i.k_inc) k_q <= k_q + 1'b1;
    if (cmd_i.sum_clr) sum_q <= '0;
    else if (cmd_i.sum_acc) sum_q <= sum_q + SW'(eig_rd);
    if (cmd_i.limit_ld) limit_q <= LW'(sum_q) * LW'(frac_q);
    if (cmd_i.eig_ld) begin
      eig_q <= eig_rd;
      esq_q <= 32'(eig_rd) * 32'(eig_rd);
    end
    if (cmd_i.prod_ld) prod_q <= 33'(signed'(vec_rd)) * 33'(diff);
    if (cmd_i.p_clr) p_q <= '0;
    else if (cmd_i.p_acc) p_q <= p_q + PW'(prod_q);
    if (cmd_i.sq_ld) begin
      if (|quo[MW-1:32]) sq_q <= lec_pkg::DIST_CAP;
      else if (sq_raw[63]) sq_q <= lec_pkg::DIST_CAP;
      else sq_q <= sq_raw;
    end
    if (cmd_i.dist_clr) dist_q <= '0;
    else if (cmd_i.dist_acc) begin
      dist_q <= (dist_sum > 65'(lec_pkg::DIST_CAP)) ? lec_pkg::DIST_CAP : dist_sum[63:0];
    end
    if (cmd_i.score_ld) begin
      score_q <= (prior_x <<< 16) - signed'({1'b0, dist_q[63:1]});
    end
    if (cmd_i.best_upd && (k_q == '0 || score_q > best_q)) begin
      best_q   <= score_q;
      best_k_q <= k_q;
    end
    if (cmd_i.out_ld) begin
      out_class_q <= 2'(best_k_q);
      out_score_q <= best_q;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // status to controller
  always_comb begin
    sts_o.start    = in_accept_i && (in_op_i == lec_pkg::OP_SAMPLE) && in_last_i;
    sts_o.c_last   = (CW'(c_q) == nc - 1'b1);
    sts_o.d_last   = (CW'(d_q) == nd - 1'b1);
    sts_o.k_last   = (KCW'(k_q) == nk - 1'b1);
    sts_o.keep     = ((64'(esq_q) << 8) > 64'(limit_q));
    sts_o.div_busy = div_busy;
    sts_o.out_free = !out_valid_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_class_o = out_class_q;
  assign out_score_o = out_score_q;

endmodule

[rtl/core/lec_ctrl.sv]
// ----------------------------------------------------------------------------
// lec_ctrl
// sequencer over classes, components and dimensions
// ----------------------------------------------------------------------------
module lec_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lec_pkg::lec_sts_t sts_i,
  output lec_pkg::lec_cmd_t cmd_o
);

  lec_pkg::lec_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lec_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      lec_pkg::ST_IDLE: begin
        cmd_o.ready = 1'b1;
        if (sts_i.start) begin
          cmd_o.c_clr   = 1'b1;
          cmd_o.sum_clr = 1'b1;
          state_d       = lec_pkg::ST_SUM_RD;
        end
      end
      lec_pkg::ST_SUM_RD: state_d = lec_pkg::ST_SUM_ACC;
      lec_pkg::ST_SUM_ACC: begin
        cmd_o.sum_acc = 1'b1;
        if (sts_i.c_last) begin
          state_d = lec_pkg::ST_LIMIT;
        end else begin
          cmd_o.c_inc = 1'b1;
          state_d     = lec_pkg::ST_SUM_RD;
        end
      end
      lec_pkg::ST_LIMIT: begin
        cmd_o.limit_ld = 1'b1;
        cmd_o.k_clr    = 1'b1;
        state_d        = lec_pkg::ST_CLS_INIT;
      end
      lec_pkg::ST_CLS_INIT: begin
        cmd_o.dist_clr = 1'b1;
        cmd_o.c_clr    = 1'b1;
        state_d        = lec_pkg::ST_EIG_RD;
      end
      lec_pkg::ST_EIG_RD: state_d = lec_pkg::ST_EIG_LD;
      lec_pkg::ST_EIG_LD: begin
        cmd_o.eig_ld = 1'b1;
        state_d      = lec_pkg::ST_KEEP_CHK;
      end
      lec_pkg::ST_KEEP_CHK: begin
        if (sts_i.keep) begin
          cmd_o.d_clr = 1'b1;
          cmd_o.p_clr = 1'b1;
          state_d     = lec_pkg::ST_MAC_RD;
        end else begin
          state_d = lec_pkg::ST_COMP_NEXT;
        end
      end
      lec_pkg::ST_MAC_RD: state_d = lec_pkg::ST_MAC_MUL;
      lec_pkg::ST_MAC_MUL: begin
        cmd_o.prod_ld = 1'b1;
        state_d       = lec_pkg::ST_MAC_ACC;
      end
      lec_pkg::ST_MAC_ACC: begin
        cmd_o.p_acc = 1'b1;
        if (sts_i.d_last) begin
          state_d = lec_pkg::ST_DIV_GO;
        end else begin
          cmd_o.d_inc = 1'b1;
          state_d     = lec_pkg::ST_MAC_RD;
        end
      end
      lec_pkg::ST_DIV_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = lec_pkg::ST_DIV_WAIT;
      end
      lec_pkg::ST_DIV_WAIT: begin
        if (!sts_i.div_busy) state_d = lec_pkg::ST_SQ;
      end
      lec_pkg::ST_SQ: begin
        cmd_o.sq_ld = 1'b1;
        state_d     = lec_pkg::ST_DIST;
      end
      lec_pkg::ST_DIST: begin
        cmd_o.dist_acc = 1'b1;
        state_d        = lec_pkg::ST_COMP_NEXT;
      end
      lec_pkg::ST_COMP_NEXT: begin
        if (sts_i.c_last) begin
          state_d = lec_pkg::ST_SCORE;
        end else begin
          cmd_o.c_inc = 1'b1;
          state_d     = lec_pkg::ST_EIG_RD;
        end
      end
      lec_pkg::ST_SCORE: begin
        cmd_o.score_ld = 1'b1;
        state_d        = lec_pkg::ST_BEST;
      end
      lec_pkg::ST_BEST: begin
        cmd_o.best_upd = 1'b1;
        if (sts_i.k_last) begin
          state_d = lec_pkg::ST_FINISH;
        end else begin
          cmd_o.k_inc = 1'b1;
          state_d     = lec_pkg::ST_CLS_INIT;
        end
      end
      lec_pkg::ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.out_ld = 1'b1;
          state_d      = lec_pkg::ST_IDLE;
        end
      end
      default: state_d = lec_pkg::ST_IDLE;
    endcase
  end

endmodule

[rtl/core/lda_eigen_classifier_core.sv]
// ----------------------------------------------------------------------------
// lda_eigen_classifier_core
// discriminant classifier over an eigenvector basis with stream ports
// ----------------------------------------------------------------------------
// Load transactions fill means, eigenvectors, eigenvalues and priors, and
// sample elements fill the sample buffer. A sample element flagged tlast
// starts a classification run during which no input is taken.
// The run steps one shared multiply-accumulate through memory reads, with
// read, multiply and accumulate states for each dimension, and runs a
// one-bit-per-cycle divider, over nd dimensions, nc components, nk classes
// and the kept retained components.
// The result sits in an output register while new loads are accepted.
module lda_eigen_classifier_core #(
  parameter int unsigned MAX_DIMS    = 64,
  parameter int unsigned MAX_CLASSES = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // row_index[5:0], column_index[11:6], value[43:12]
  input  logic [2:0]  s_axis_tuser,  // command[2:0]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // class_index[1:0], best_score[65:2]
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  lec_pkg::lec_cmd_t cmd;
  lec_pkg::lec_sts_t sts;
  logic              accept;
  logic [1:0]        out_class;
  logic [63:0]       out_score;

  // input handshake
  assign s_axis_tready = cmd.ready;
  assign accept        = s_axis_tvalid && cmd.ready;

  lec_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .sts_i (sts),
    .cmd_o (cmd)
  );

  lec_datapath #(
    .MAX_DIMS   (MAX_DIMS),
    .MAX_CLASSES(MAX_CLASSES)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_accept_i(accept),
    .in_op_i    (s_axis_tuser),
    .in_row_i   (s_axis_tdata[5:0]),
    .in_col_i   (s_axis_tdata[11:6]),
    .in_value_i (s_axis_tdata[43:12]),
    .in_last_i  (s_axis_tlast),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_class_o(out_class),
    .out_score_o(out_score)
  );

  // output packing
  assign m_axis_tdata = {6'b0, out_score, out_class};

  // a last sample element starts a run, closing the input side
  a_start_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sts.start) |=> !s_axis_tready)
    else $error("input still open after a classification start");

  // a new result only comes out of a classification run
  a_result_from_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without a classification run");

  // the divider only runs while the input side is closed
  a_div_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.div_busy |-> !s_axis_tready)
    else $error("divider busy while accepting input");

endmodule
